// File: rtl/core/dsrb_pkg.sv
// Shared types and codes for the decimating sample ring buffer.
// Holds the request and result structs, command classes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package dsrb_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_SAVE    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Read status codes.
  localparam logic [1:0] ST_INACTIVE = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_DATA     = 2'd2;

  // Run mode that enables capture.
  localparam logic [1:0] RUN_CAPTURE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BYTES = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = 1;
  localparam int unsigned Q_CNT_W     = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] sample_word;
  } request_t;

  typedef struct packed {
    logic [1:0]  read_status;
    logic        overflow_seen;
    logic [63:0] data_word;
    logic [6:0]  sample_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [31:0] decimation;
    logic [10:0] slot_count;
    logic [6:0]  read_limit;
    logic [3:0]  sample_bytes;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_SAVE,
    CMD_READ,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] word;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COUNT,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/core/dsrb_front.sv
// Front end: accepts requests, classifies them and queues commands.
// Depends on dsrb_pkg.
`timescale 1ns / 1ps

module dsrb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dsrb_pkg::request_t cmd,
  input  dsrb_pkg::cfg_t  cfg,
  output logic            busy,
  output logic            q_valid,
  output dsrb_pkg::cmd_t  q_head,
  input  logic            pop
);

  dsrb_pkg::cmd_t entries [dsrb_pkg::QUEUE_DEPTH];
  logic [dsrb_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [dsrb_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [dsrb_pkg::Q_CNT_W-1:0] fill;
  logic [dsrb_pkg::Q_CNT_W-1:0] fill_next;

  logic           keep;
  logic           push;
  logic           do_pop;
  dsrb_pkg::cmd_t cls;
  logic [63:0]    mask;

  // Byte mask from the valid-byte setting; zero keeps nothing, eight or more keeps all.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = ({1'b0, cfg.sample_bytes} > 5'(b)) ? 8'hFF : 8'h00;
    end
  end

  // Classify the request; unknown codes and saves outside capture are dropped here.
  always_comb begin
    keep      = 1'b0;
    cls.kind  = dsrb_pkg::CMD_SAVE;
    cls.word  = cmd.sample_word & mask;
    case (cmd.op)
      dsrb_pkg::OP_SAVE: begin
        keep     = (cfg.run_mode == dsrb_pkg::RUN_CAPTURE);
        cls.kind = dsrb_pkg::CMD_SAVE;
      end
      dsrb_pkg::OP_READ: begin
        keep     = 1'b1;
        cls.kind = dsrb_pkg::CMD_READ;
      end
      dsrb_pkg::OP_RESTART: begin
        keep     = 1'b1;
        cls.kind = dsrb_pkg::CMD_RESTART;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy    = (fill == dsrb_pkg::Q_CNT_W'(dsrb_pkg::QUEUE_DEPTH));
  assign push    = start && !busy && keep;
  assign q_valid = (fill != '0);
  assign do_pop  = pop && q_valid;
  assign q_head  = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !do_pop) begin
      fill_next = fill + 1'b1;
    end else if (!push && do_pop) begin
      fill_next = fill - 1'b1;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

endmodule

// File: rtl/core/dsrb_back.sv
// Back end: runs queued commands against the sample ring and drives results.
// Holds the sample memory, ring pointers, tick counter and overflow flag.
// Depends on dsrb_pkg.
`timescale 1ns / 1ps

module dsrb_back #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  dsrb_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  dsrb_pkg::cmd_t    q_head,
  output logic              pop,
  output logic              strobe,
  output dsrb_pkg::result_t result
);

  localparam int unsigned PTR_W = $clog2(MAX_SLOTS);
  localparam int unsigned LEN_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W = (LEN_W > 11) ? LEN_W : 11;

  logic [63:0] mem [MAX_SLOTS];
  logic [63:0] mem_q;
  logic        mem_we;

  dsrb_pkg::back_state_t state, state_next;
  logic [PTR_W-1:0] write_slot, write_slot_next;
  logic [PTR_W-1:0] read_slot, read_slot_next;
  logic [PTR_W-1:0] walk_ptr, walk_ptr_next;
  logic [31:0]      tick_count, tick_count_next;
  logic             dropped, dropped_next;
  logic             ovf, ovf_next;
  logic [6:0]       cnt, cnt_next;
  logic [6:0]       emitted, emitted_next;
  logic             strobe_next;
  dsrb_pkg::result_t result_next;

  logic [CMP_W-1:0] ring_len;
  logic [CMP_W-1:0] sc_ext;
  logic [6:0]       read_max;
  logic [PTR_W-1:0] wr_adv;
  logic [PTR_W-1:0] rd_adv;
  logic [PTR_W-1:0] walk_adv;
  logic [31:0]      tick_inc;
  logic             active;
  logic             last_one;

  // Step a pointer around the ring, wrapping at or past the ring length.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CMP_W-1:0] n);
    logic [CMP_W-1:0] p1;
    p1 = CMP_W'(p) + CMP_W'(1);
    return (p1 >= n) ? '0 : PTR_W'(p1);
  endfunction

  // Clamp the settings into their working ranges.
  assign sc_ext   = CMP_W'(cfg.slot_count);
  assign ring_len = (sc_ext < CMP_W'(2)) ? CMP_W'(2) :
                    (sc_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : sc_ext;
  assign read_max = (cfg.read_limit < 7'd1) ? 7'd1 :
                    (cfg.read_limit > 7'(MAX_READ)) ? 7'(MAX_READ) : cfg.read_limit;

  assign wr_adv   = advance(write_slot, ring_len);
  assign rd_adv   = advance(read_slot, ring_len);
  assign walk_adv = advance(walk_ptr, ring_len);
  assign tick_inc = tick_count + 32'd1;
  assign active   = (cfg.run_mode == dsrb_pkg::RUN_CAPTURE);
  assign last_one = ((emitted + 7'd1) == cnt);

  // Command sequencer: next state, pointer updates and result formation.
  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    walk_ptr_next   = walk_ptr;
    tick_count_next = tick_count;
    dropped_next    = dropped;
    ovf_next        = ovf;
    cnt_next        = cnt;
    emitted_next    = emitted;
    strobe_next     = 1'b0;
    result_next     = result;
    mem_we          = 1'b0;
    pop             = 1'b0;
    case (state)
      dsrb_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_head.kind)
            dsrb_pkg::CMD_SAVE: begin
              if (tick_inc >= cfg.decimation) begin
                tick_count_next = '0;
                if (wr_adv == read_slot) begin
                  dropped_next = 1'b1;
                end else begin
                  mem_we          = 1'b1;
                  write_slot_next = wr_adv;
                end
              end else begin
                tick_count_next = tick_inc;
              end
            end
            dsrb_pkg::CMD_RESTART: begin
              write_slot_next = '0;
              read_slot_next  = '0;
            end
            dsrb_pkg::CMD_READ: begin
              if (!active || (write_slot == read_slot)) begin
                strobe_next               = 1'b1;
                result_next.read_status   = active ? dsrb_pkg::ST_EMPTY
                                                   : dsrb_pkg::ST_INACTIVE;
                result_next.overflow_seen = 1'b0;
                result_next.data_word     = '0;
                result_next.sample_count  = '0;
                result_next.last          = 1'b1;
              end else begin
                walk_ptr_next = read_slot;
                cnt_next      = '0;
                ovf_next      = dropped;
                state_next    = dsrb_pkg::BK_COUNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dsrb_pkg::BK_COUNT: begin
        // Walk the ring to size this read before the first sample goes out.
        walk_ptr_next = walk_adv;
        cnt_next      = cnt + 7'd1;
        emitted_next  = '0;
        if (((cnt + 7'd1) >= read_max) || (walk_adv == write_slot)) begin
          state_next = dsrb_pkg::BK_FETCH;
        end
      end
      dsrb_pkg::BK_FETCH: begin
        state_next = dsrb_pkg::BK_EMIT;
      end
      dsrb_pkg::BK_EMIT: begin
        strobe_next               = 1'b1;
        result_next.read_status   = dsrb_pkg::ST_DATA;
        result_next.overflow_seen = ovf;
        result_next.data_word     = mem_q;
        result_next.sample_count  = cnt;
        result_next.last          = last_one;
        read_slot_next            = rd_adv;
        emitted_next              = emitted + 7'd1;
        if (last_one) begin
          dropped_next = 1'b0;
          state_next   = dsrb_pkg::BK_IDLE;
        end else begin
          state_next = dsrb_pkg::BK_FETCH;
        end
      end
      default: begin
        state_next = dsrb_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dsrb_pkg::BK_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      tick_count <= '0;
      dropped    <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      tick_count <= tick_count_next;
      dropped    <= dropped_next;
      strobe     <= strobe_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    walk_ptr <= walk_ptr_next;
    ovf      <= ovf_next;
    cnt      <= cnt_next;
    emitted  <= emitted_next;
    result   <= result_next;
  end

  // Sample memory: one write port at the write slot, registered read at the read slot.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_slot] <= q_head.word;
    end
    mem_q <= mem[read_slot];
  end

endmodule

// File: rtl/core/decimating_sample_ring_buffer.sv
// Decimating sample ring buffer: a two-entry command queue feeds a back end that runs one
// command at a time. Save and restart update the ring when the back end pops them from the
// queue; a status result is registered onto the ports; a data read first walks the ring to
// count its samples, then alternates a fetch state and an emit state, one sample per emit.
// Results cannot be stalled. Synchronous reset clears pointers, tick count, overflow flag,
// queue and configuration registers.
`timescale 1ns / 1ps

module decimating_sample_ring_buffer #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  dsrb_pkg::request_t                   cmd,
  output logic                                 busy,
  output logic                                 strobe,
  output dsrb_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [dsrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsrb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dsrb_pkg::cfg_t cfg;
  logic           q_valid;
  dsrb_pkg::cmd_t q_head;
  logic           pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_mode     <= 2'd0;
      cfg.decimation   <= 32'd1;
      cfg.slot_count   <= 11'd1024;
      cfg.read_limit   <= 7'd64;
      cfg.sample_bytes <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        dsrb_pkg::REG_RUN_MODE:     cfg.run_mode     <= cfg_data[1:0];
        dsrb_pkg::REG_DECIMATION:   cfg.decimation   <= cfg_data[31:0];
        dsrb_pkg::REG_SLOT_COUNT:   cfg.slot_count   <= cfg_data[10:0];
        dsrb_pkg::REG_READ_LIMIT:   cfg.read_limit   <= cfg_data[6:0];
        dsrb_pkg::REG_SAMPLE_BYTES: cfg.sample_bytes <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  dsrb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .cfg     (cfg),
    .busy    (busy),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop)
  );

  dsrb_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_READ  (MAX_READ)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// File: rtl/core/dsrb_checker.sv
// Port-level checks for the decimating sample ring buffer, bound to the top level.
// Depends on dsrb_pkg and decimating_sample_ring_buffer.
`timescale 1ns / 1ps

module dsrb_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              strobe,
  input dsrb_pkg::result_t result
);

  // A status-only result is a single, empty, final result.
  a_status_empty: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.read_status != dsrb_pkg::ST_DATA)) |->
      (result.last && (result.data_word == '0) && (result.sample_count == '0) &&
       !result.overflow_seen))
    else $error("status result carries data or is not final");

  // A data result always reports a nonzero count of at most 64.
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.read_status == dsrb_pkg::ST_DATA)) |->
      ((result.sample_count != '0) && (result.sample_count <= 7'd64)))
    else $error("data result with bad sample count");

  // Within one read, strobe drops between samples and the next sample keeps the same count.
  a_burst_pace: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> (!strobe ##1 (strobe &&
      (result.read_status == dsrb_pkg::ST_DATA) &&
      (result.sample_count == $past(result.sample_count, 2)) &&
      (result.overflow_seen == $past(result.overflow_seen, 2)))))
    else $error("read burst broken");

  // A reset cycle leaves the queue empty and no result out, so requests are taken.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> (!busy && !strobe))
    else $error("busy or strobe right after reset");

endmodule

bind decimating_sample_ring_buffer dsrb_checker u_dsrb_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// File: bench/decimating_sample_ring_buffer_tb.sv
// Self-checking testbench for the decimating sample ring buffer.
// Sends save, read and restart requests and checks every returned result against an
// in-bench ring model. Depends on dsrb_pkg and decimating_sample_ring_buffer.
`timescale 1ns / 1ps

module decimating_sample_ring_buffer_tb;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned MAX_READ = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_PAUSED = 2'd1;
  localparam logic [1:0] RUN_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 260;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT = 3000;

  // Ring model: pointers, tick counter, overflow flag, registers, and the
  // results the block still owes.
  class capture_ring_model;
    logic [63:0] slot_mem [MAX_SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    logic [31:0] tick_cnt;
    logic dropped;
    logic [1:0] run_mode;
    logic [31:0] decim;
    logic [10:0] slots;
    logic [6:0] rd_limit;
    logic [3:0] smp_bytes;
    dsrb_pkg::result_t due_readouts[$];
    int unsigned errors;

    function new();
      wr_slot = 0;
      rd_slot = 0;
      tick_cnt = '0;
      dropped = 1'b0;
      run_mode = RUN_STOPPED;
      decim = 32'd1;
      slots = 11'd1024;
      rd_limit = 7'd64;
      smp_bytes = 4'd8;
      errors = 0;
    endfunction

    // Ring length with out-of-range settings clamped.
    function int unsigned ring_len();
      if (slots < 2) return 2;
      if (slots > MAX_SLOTS) return MAX_SLOTS;
      return int'(slots);
    endfunction

    // A pointer at or past the ring length wraps to zero on its next advance.
    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= ring_len()) ? 0 : p + 1;
    endfunction

    function void write_reg(logic [dsrb_pkg::CFG_IDX_W-1:0] idx,
                            logic [dsrb_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dsrb_pkg::REG_RUN_MODE: run_mode = data[1:0];
        dsrb_pkg::REG_DECIMATION: decim = data;
        dsrb_pkg::REG_SLOT_COUNT: slots = data[10:0];
        dsrb_pkg::REG_READ_LIMIT: rd_limit = data[6:0];
        dsrb_pkg::REG_SAMPLE_BYTES: smp_bytes = data[3:0];
        default: ;
      endcase
    endfunction

    // Update the ring for one accepted request and queue the results it causes.
    function void apply_request(dsrb_pkg::request_t req);
      logic [63:0] keep;
      int unsigned limit;
      int unsigned count;
      int unsigned p;
      logic ovf;
      dsrb_pkg::result_t r;
      bit active;
      active = (run_mode == dsrb_pkg::RUN_CAPTURE);
      case (req.op)
        dsrb_pkg::OP_SAVE: begin
          if (active) begin
            tick_cnt = tick_cnt + 32'd1;
            if (tick_cnt >= decim) begin
              tick_cnt = '0;
              if (next_slot(wr_slot) == rd_slot) begin
                dropped = 1'b1;
              end else begin
                if (smp_bytes == 0) keep = '0;
                else if (smp_bytes >= 8) keep = '1;
                else keep = (64'd1 << (8 * smp_bytes)) - 64'd1;
                slot_mem[wr_slot] = req.sample_word & keep;
                wr_slot = next_slot(wr_slot);
              end
            end
          end
        end
        dsrb_pkg::OP_RESTART: begin
          wr_slot = 0;
          rd_slot = 0;
        end
        dsrb_pkg::OP_READ: begin
          if (!active || wr_slot == rd_slot) begin
            // Inactive or empty: one status result, overflow flag untouched.
            r = '0;
            r.read_status = active ? dsrb_pkg::ST_EMPTY : dsrb_pkg::ST_INACTIVE;
            r.last = 1'b1;
            due_readouts.push_back(r);
          end else begin
            limit = (rd_limit < 1) ? 1 : (rd_limit > MAX_READ) ? MAX_READ : int'(rd_limit);
            count = 0;
            p = rd_slot;
            while (count < limit && p != wr_slot) begin
              p = next_slot(p);
              count++;
            end
            ovf = dropped;
            for (int unsigned k = 0; k < count; k++) begin
              r.read_status = dsrb_pkg::ST_DATA;
              r.overflow_seen = ovf;
              r.data_word = slot_mem[rd_slot];
              r.sample_count = 7'(count);
              r.last = (k + 1 == count);
              due_readouts.push_back(r);
              rd_slot = next_slot(rd_slot);
            end
            dropped = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one returned result with the oldest one owed.
    function void match_readout(dsrb_pkg::result_t got);
      dsrb_pkg::result_t want;
      if (due_readouts.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %0h", $time, got);
        errors++;
        return;
      end
      want = due_readouts.pop_front();
      field_check("read_status", want.read_status, got.read_status);
      field_check("overflow_seen", want.overflow_seen, got.overflow_seen);
      field_check("data_word", want.data_word, got.data_word);
      field_check("sample_count", want.sample_count, got.sample_count);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  dsrb_pkg::request_t cmd = '0;
  logic busy;
  logic strobe;
  dsrb_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [dsrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dsrb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned sent = 0;
  capture_ring_model board = new();

  decimating_sample_ring_buffer u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .strobe(strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (!rst && strobe) board.match_readout(result);
  end

  // Watchdog: too many cycles with no request or result accepted ends the run.
  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || strobe) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request, idling first at the current rate, and hold it until taken.
  task automatic send_request(input logic [1:0] op, input logic [63:0] word);
    dsrb_pkg::request_t req;
    req.op = op;
    req.sample_word = word;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= req;
    do @(posedge clk); while (busy);
    board.apply_request(req);
    if (op != OP_UNUSED) sent++;
  endtask

  // Stop sending until all owed results are in, then let queued saves finish.
  task automatic settle();
    start <= 1'b0;
    while (board.due_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dsrb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dsrb_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Empty the ring so a new length cannot expose unwritten slots, wait for
  // the block to go idle, then load all five registers.
  task automatic begin_phase(input logic [1:0] mode, input logic [31:0] decim,
                             input logic [10:0] slots, input logic [6:0] limit,
                             input logic [3:0] nbytes);
    if (board.wr_slot != board.rd_slot) begin
      send_request(dsrb_pkg::OP_RESTART, {$urandom, $urandom});
    end
    settle();
    write_reg(dsrb_pkg::REG_RUN_MODE, {30'd0, mode});
    write_reg(dsrb_pkg::REG_DECIMATION, decim);
    write_reg(dsrb_pkg::REG_SLOT_COUNT, {21'd0, slots});
    write_reg(dsrb_pkg::REG_READ_LIMIT, {25'd0, limit});
    write_reg(dsrb_pkg::REG_SAMPLE_BYTES, {28'd0, nbytes});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_len;
    int unsigned pick;
    logic [1:0] mode;
    logic [31:0] decim;
    logic [10:0] slots;
    logic [6:0] limit;
    logic [63:0] word;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset values: stopped, so reads are inactive and saves ignored.
    send_request(dsrb_pkg::OP_READ, '0);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(OP_UNUSED, '1);

    // Undefined run mode behaves as stopped.
    begin_phase(RUN_UNUSED, 32'd1, 11'd1024, 7'd64, 4'd8);
    send_request(dsrb_pkg::OP_READ, '0);
    send_request(dsrb_pkg::OP_SAVE, 64'h0123_4567_89AB_CDEF);

    // Decimation zero, slot count and read limit below range, no valid bytes:
    // the two-slot ring holds one sample, the second save overflows.
    begin_phase(dsrb_pkg::RUN_CAPTURE, 32'd0, 11'd1, 7'd0, 4'd0);
    send_request(dsrb_pkg::OP_READ, '0);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(dsrb_pkg::OP_READ, '0);
    send_request(dsrb_pkg::OP_READ, '0);

    // Settings above range clamp; full-width samples; restart empties the ring.
    begin_phase(dsrb_pkg::RUN_CAPTURE, 32'd1, 11'd2047, 7'd127, 4'd15);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(dsrb_pkg::OP_SAVE, '0);
    send_request(dsrb_pkg::OP_SAVE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(dsrb_pkg::OP_SAVE, 64'h5555_5555_5555_5555);
    send_request(dsrb_pkg::OP_READ, '0);
    send_request(dsrb_pkg::OP_SAVE, 64'hFEDC_BA98_7654_3210);
    send_request(dsrb_pkg::OP_RESTART, '0);
    send_request(dsrb_pkg::OP_READ, '0);

    // Every third tick stores three low bytes; the read is cut to two.
    begin_phase(dsrb_pkg::RUN_CAPTURE, 32'd3, 11'd4, 7'd2, 4'd3);
    repeat (7) send_request(dsrb_pkg::OP_SAVE, {$urandom, $urandom});
    send_request(dsrb_pkg::OP_READ, '0);

    // Paused: reads inactive, saves do not count.
    begin_phase(RUN_PAUSED, 32'd1, 11'd4, 7'd2, 4'd3);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(dsrb_pkg::OP_READ, '0);

    // Largest decimation: no sample is ever stored.
    begin_phase(dsrb_pkg::RUN_CAPTURE, 32'hFFFF_FFFF, 11'd5, 7'd64, 4'd1);
    send_request(dsrb_pkg::OP_SAVE, '1);
    send_request(dsrb_pkg::OP_READ, '0);

    // Random phases, each with its own register setting and idle rate.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      pick = $urandom_range(9);
      mode = (pick <= 6) ? dsrb_pkg::RUN_CAPTURE : (pick == 7) ? RUN_PAUSED :
             (pick == 8) ? RUN_STOPPED : RUN_UNUSED;
      case ($urandom_range(7))
        0: decim = 32'd0;
        1: decim = $urandom;
        2, 3: decim = 32'd1;
        default: decim = $urandom_range(2, 4);
      endcase
      case ($urandom_range(9))
        0: slots = 11'($urandom_range(0, 1));
        1: slots = 11'd1024;
        2: slots = 11'($urandom_range(1025, 2047));
        3: slots = 11'($urandom_range(2, 200));
        default: slots = 11'($urandom_range(2, 9));
      endcase
      case ($urandom_range(5))
        0: limit = 7'd0;
        1: limit = 7'($urandom_range(65, 127));
        2: limit = 7'd64;
        default: limit = 7'($urandom_range(1, 8));
      endcase
      idle_pct = 0;
      begin_phase(mode, decim, slots, limit, 4'($urandom_range(15)));
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 66;
        default: idle_pct = 38;
      endcase

      phase_len = $urandom_range(25, 45);
      repeat (phase_len) begin
        case ($urandom_range(9))
          0: word = '0;
          1: word = '1;
          default: word = {$urandom, $urandom};
        endcase
        pick = $urandom_range(99);
        if (pick < 58) send_request(dsrb_pkg::OP_SAVE, word);
        else if (pick < 88) send_request(dsrb_pkg::OP_READ, word);
        else if (pick < 94) send_request(dsrb_pkg::OP_RESTART, word);
        else if (pick < 97) send_request(OP_UNUSED, word);
        else settle();
      end
      phase++;
    end

    settle();
    if (board.errors == 0 && board.due_readouts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
